[src/wsfu_pkg.sv]
// Shared types and constants for the WebSocket frame unmasker.
`timescale 1ns / 1ps

package wsfu_pkg;

    localparam int BYTE_W = 8;
    localparam int OPCODE_W = 4;
    localparam int LEN_W = 64;
    localparam int KEY_W = 32;
    localparam int EXT_CNT_W = 4;
    localparam int KEY_IDX_W = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;
    localparam logic [EXT_CNT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [EXT_CNT_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [EXT_CNT_W-1:0] KEY_BYTES = 4'd4;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4,
        PH_SKIP = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_UNMASKED = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic                frame_fin;
        logic [OPCODE_W-1:0] frame_opcode;
        status_t             status;
        logic                last;
    } result_t;

endpackage

[src/wsfu_parser.sv]
// Frame header parser, length and key capture, and payload unmasking.
`timescale 1ns / 1ps

module wsfu_parser
    import wsfu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              beat,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              res_valid,
    output result_t           res
);

    phase_t                 state_reg, state_next;
    logic                   fin_reg, fin_next;
    logic [OPCODE_W-1:0]    opcode_reg, opcode_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic [EXT_CNT_W-1:0]   ext_reg, ext_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [KEY_IDX_W-1:0]   kidx_reg, kidx_next;
    logic                   skip_reg, skip_next;

    logic [6:0]             len7;
    logic [LEN_W-1:0]       rem_dec;
    logic [LEN_W-1:0]       rem_shift;
    logic [EXT_CNT_W-1:0]   ext_dec;
    logic [BYTE_W-1:0]      key_byte;

    assign len7      = in_byte[6:0];
    assign rem_dec   = rem_reg - {{(LEN_W-1){1'b0}}, 1'b1};
    assign rem_shift = {rem_reg[LEN_W-BYTE_W-1:0], in_byte};
    assign ext_dec   = ext_reg - {{(EXT_CNT_W-1){1'b0}}, 1'b1};
    assign key_byte  = key_reg[{~kidx_reg, 3'b000} +: BYTE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= PH_HDR0;
            fin_reg    <= 1'b0;
            opcode_reg <= '0;
            rem_reg    <= '0;
            ext_reg    <= '0;
            key_reg    <= '0;
            kidx_reg   <= '0;
            skip_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            rem_reg    <= rem_next;
            ext_reg    <= ext_next;
            key_reg    <= key_next;
            kidx_reg   <= kidx_next;
            skip_reg   <= skip_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        fin_next         = fin_reg;
        opcode_next      = opcode_reg;
        rem_next         = rem_reg;
        ext_next         = ext_reg;
        key_next         = key_reg;
        kidx_next        = kidx_reg;
        skip_next        = skip_reg;
        res_valid        = 1'b0;
        res.payload_byte = '0;
        res.frame_fin    = fin_reg;
        res.frame_opcode = opcode_reg;
        res.status       = ST_DATA;
        res.last         = 1'b0;
        if (beat)
        begin
            case (state_reg)
                PH_HDR1:
                begin
                    skip_next = ~in_byte[7];
                    rem_next  = '0;
                    if (len7 == LEN16_CODE)
                    begin
                        ext_next   = EXT16_BYTES;
                        state_next = PH_EXT;
                    end
                    else if (len7 == LEN64_CODE)
                    begin
                        ext_next   = EXT64_BYTES;
                        state_next = PH_EXT;
                    end
                    else
                    begin
                        rem_next = {{(LEN_W-7){1'b0}}, len7};
                        if (!in_byte[7])
                        begin
                            state_next = (len7 == 7'd0) ? PH_HDR0 : PH_SKIP;
                        end
                        else
                        begin
                            state_next = PH_KEY;
                            ext_next   = KEY_BYTES;
                            key_next   = '0;
                        end
                    end
                    if (!in_byte[7])
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_UNMASKED;
                        res.last   = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    rem_next = rem_shift;
                    ext_next = ext_dec;
                    if (ext_dec == '0)
                    begin
                        if (skip_reg)
                        begin
                            state_next = (rem_shift == '0) ? PH_HDR0 : PH_SKIP;
                        end
                        else
                        begin
                            state_next = PH_KEY;
                            ext_next   = KEY_BYTES;
                            key_next   = '0;
                        end
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[KEY_W-BYTE_W-1:0], in_byte};
                    ext_next = ext_dec;
                    if (ext_dec == '0)
                    begin
                        kidx_next = '0;
                        if (rem_reg == '0)
                        begin
                            state_next = PH_HDR0;
                            res_valid  = 1'b1;
                            res.status = ST_EMPTY;
                            res.last   = 1'b1;
                        end
                        else
                        begin
                            state_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    kidx_next        = kidx_reg + 2'd1;
                    rem_next         = rem_dec;
                    res_valid        = 1'b1;
                    res.payload_byte = in_byte ^ key_byte;
                    res.last         = (rem_dec == '0);
                    if (rem_dec == '0)
                    begin
                        state_next = PH_HDR0;
                    end
                end
                PH_SKIP:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        state_next = PH_HDR0;
                    end
                end
                default:
                begin
                    fin_next    = in_byte[7];
                    opcode_next = in_byte[OPCODE_W-1:0];
                    state_next  = PH_HDR1;
                end
            endcase
        end
    end

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != ST_DATA |-> res.last && res.payload_byte == '0)
        else $error("marker result without last or with data");

    a_data_emits: assert property (@(posedge clk) disable iff (!rst_n)
        beat && state_reg == PH_DATA |-> res_valid && res.status == ST_DATA)
        else $error("payload beat gave no data result");

    a_skip_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == PH_SKIP || state_reg == PH_DATA |-> rem_reg != '0)
        else $error("payload phase with zero remaining length");

    a_hdr1_follows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == PH_HDR1 |-> $past(state_reg) == PH_HDR1 || $past(beat))
        else $error("second header phase entered without a beat");

endmodule

[src/wsfu_out_reg.sv]
// Result register that decouples the output handshake from the input side.
`timescale 1ns / 1ps

module wsfu_out_reg
    import wsfu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    assign room      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (room)
        begin
            valid_next = load;
            if (load)
            begin
                res_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

[src/websocket_frame_unmasker_core.sv]
// Top level of the WebSocket client frame deframer and unmasker.
// A payload or marker result is registered and appears on m_tvalid in the cycle after its input beat.
// Throughput: one input byte per clock, sustained while the output is taken.
// The result register frees its slot in the same cycle it is drained, so no bubble.
// Reset: rst_n clears the parser to await the first header byte and empties the output.
`timescale 1ns / 1ps

module websocket_frame_unmasker_core
    import wsfu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] in_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [8] frame_fin, [12:9] frame_opcode
    output logic [OUT_TUSER_W-1:0] m_tuser,   // [1:0] status
    output logic                   m_tlast
);

    logic    beat;
    logic    room;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign s_tready = room;
    assign beat     = s_tvalid && room;

    wsfu_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfu_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {3'b000, out_res.frame_opcode, out_res.frame_fin, out_res.payload_byte};
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.last;

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for the WebSocket frame unmasker with a byte-level deframer predictor.
`timescale 1ns / 1ps

module tb_top;
    import wsfu_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_BYTES = 650;
    localparam int LONG_HOLD_AT = 300;
    localparam int LONG_HOLD_CYCLES = 160;
    localparam int PACE_MARGIN = 60;

    localparam int LEN7 = 0;
    localparam int LEN16 = 1;
    localparam int LEN64 = 2;

    localparam logic [3:0] OP_CONT = 4'h0;
    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING = 4'h9;
    localparam logic [3:0] OP_PONG = 4'hA;
    localparam logic [3:0] OP_RSVD_F = 4'hF;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    logic [7:0] wire_bytes[$];
    result_t    expected_beats[$];

    phase_t          parse_ph = PH_HDR0;
    logic            hdr_fin = 1'b0;
    logic [3:0]      hdr_opcode = '0;
    logic [LEN_W-1:0] bytes_left = '0;
    logic [EXT_CNT_W-1:0] field_cnt = '0;
    logic [KEY_W-1:0] mask_word = '0;
    logic [KEY_IDX_W-1:0] mask_sel = '0;
    logic            skipping = 1'b0;

    int  fail_count = 0;
    int  cycle_count = 0;
    int  in_count = 0;
    bit  in_fire = 1'b0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  long_left = 0;
    bit  long_done = 1'b0;

    websocket_frame_unmasker_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic bit pace();
        return (wire_bytes.size() > PACE_MARGIN);
    endfunction

    function automatic void length_known();
        if (skipping)
        begin
            parse_ph = (bytes_left == 0) ? PH_HDR0 : PH_SKIP;
        end
        else
        begin
            parse_ph = PH_KEY;
            field_cnt = KEY_BYTES;
            mask_word = '0;
        end
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        result_t r;
        bit      emit;
        r = '0;
        emit = 1'b0;
        case (parse_ph)
            PH_HDR1:
            begin
                skipping = ~b[7];
                bytes_left = '0;
                if (b[6:0] == LEN16_CODE)
                begin
                    field_cnt = EXT16_BYTES;
                    parse_ph = PH_EXT;
                end
                else if (b[6:0] == LEN64_CODE)
                begin
                    field_cnt = EXT64_BYTES;
                    parse_ph = PH_EXT;
                end
                else
                begin
                    bytes_left = LEN_W'(b[6:0]);
                    length_known();
                end
                if (skipping)
                begin
                    r.status = ST_UNMASKED;
                    r.last = 1'b1;
                    emit = 1'b1;
                end
            end
            PH_EXT:
            begin
                bytes_left = {bytes_left[LEN_W-9:0], b};
                field_cnt = field_cnt - EXT_CNT_W'(1);
                if (field_cnt == 0)
                    length_known();
            end
            PH_KEY:
            begin
                mask_word = {mask_word[KEY_W-9:0], b};
                field_cnt = field_cnt - EXT_CNT_W'(1);
                if (field_cnt == 0)
                begin
                    mask_sel = '0;
                    if (bytes_left == 0)
                    begin
                        parse_ph = PH_HDR0;
                        r.status = ST_EMPTY;
                        r.last = 1'b1;
                        emit = 1'b1;
                    end
                    else
                        parse_ph = PH_DATA;
                end
            end
            PH_DATA:
            begin
                r.payload_byte = b ^ mask_word[8*(3-mask_sel) +: 8];
                mask_sel = mask_sel + KEY_IDX_W'(1);
                bytes_left = bytes_left - LEN_W'(1);
                if (bytes_left == 0)
                    parse_ph = PH_HDR0;
                r.status = ST_DATA;
                r.last = (bytes_left == 0);
                emit = 1'b1;
            end
            PH_SKIP:
            begin
                bytes_left = bytes_left - LEN_W'(1);
                if (bytes_left == 0)
                    parse_ph = PH_HDR0;
            end
            default:
            begin
                hdr_fin = b[7];
                hdr_opcode = b[3:0];
                parse_ph = PH_HDR1;
            end
        endcase
        if (emit)
        begin
            r.frame_fin = hdr_fin;
            r.frame_opcode = hdr_opcode;
            expected_beats.push_back(r);
        end
    endtask

    // nbytes may be fewer than len to leave a frame open at the end
    task automatic push_frame(input bit fin, input logic [3:0] op, input bit masked,
                              input int kind, input logic [63:0] len,
                              input logic [31:0] key, input int nbytes);
        logic [6:0] len7;
        wire_bytes.push_back({fin, 3'($urandom_range(0, 7)), op});
        if (kind == LEN16)
            len7 = LEN16_CODE;
        else if (kind == LEN64)
            len7 = LEN64_CODE;
        else
            len7 = len[6:0];
        wire_bytes.push_back({masked, len7});
        if (kind == LEN16)
        begin
            wire_bytes.push_back(len[15:8]);
            wire_bytes.push_back(len[7:0]);
        end
        else if (kind == LEN64)
        begin
            for (int i = 7; i >= 0; i--)
                wire_bytes.push_back(len[8*i +: 8]);
        end
        if (masked)
        begin
            for (int i = 3; i >= 0; i--)
                wire_bytes.push_back(key[8*i +: 8]);
        end
        for (int i = 0; i < nbytes; i++)
            wire_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t    want;
        logic [15:0] want_data;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t unexpected beat: tdata=%h tuser=%0d tlast=%0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    want_data = {3'b000, want.frame_opcode, want.frame_fin, want.payload_byte};
                    if (m_tdata !== want_data || m_tuser !== want.status
                        || m_tlast !== want.last)
                    begin
                        $display("%0t mismatch: expected tdata=%h tuser=%0d tlast=%0b,",
                                 $time, want_data, want.status, want.last,
                                 " got tdata=%h tuser=%0d tlast=%0b",
                                 m_tdata, m_tuser, m_tlast);
                        fail_count++;
                    end
                end
            end
            in_fire = s_tvalid && s_tready;
            if (in_fire)
            begin
                deframe_byte(s_tdata);
                in_count++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (wire_bytes.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= wire_bytes.pop_front();
                if (pace() && long_left == 0 && $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 14);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_done && in_count >= LONG_HOLD_AT)
            begin
                long_done = 1'b1;
                long_left = LONG_HOLD_CYCLES;
            end
            if (long_left > 0)
            begin
                m_tready <= 1'b0;
                long_left = long_left - 1;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (pace() && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 13);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int          pick;
        int          kind;
        bit          masked;
        logic [63:0] len;

        // empty frames, shortest frames, both extended encodings, unminimized lengths
        push_frame(1'b1, OP_RSVD_F, 1'b1, LEN7, 64'd0, 32'hFFFF_FFFF, 0);
        push_frame(1'b0, OP_CONT, 1'b0, LEN7, 64'd0, 32'h0, 0);
        push_frame(1'b1, OP_TEXT, 1'b1, LEN7, 64'd1, 32'hFFFF_FFFF, 1);
        push_frame(1'b0, OP_BINARY, 1'b0, LEN7, 64'd3, 32'h0, 3);
        push_frame(1'b1, OP_CLOSE, 1'b1, LEN16, 64'd2, 32'h0000_0000, 2);
        push_frame(1'b1, OP_PING, 1'b0, LEN64, 64'd1, 32'h0, 1);
        push_frame(1'b0, OP_PONG, 1'b1, LEN64, 64'd0, 32'h8040_2010, 0);
        push_frame(1'b1, OP_BINARY, 1'b1, LEN7, 64'd5, 32'hA5C3_0F96, 5);

        while (wire_bytes.size() < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 9);
            kind = (pick < 7) ? LEN7 : (pick < 9) ? LEN16 : LEN64;
            masked = ($urandom_range(0, 7) != 0);
            len = 64'($urandom_range(0, 12));
            if (kind == LEN7 && $urandom_range(0, 11) == 0)
                len = 64'($urandom_range(0, 125));
            if (kind == LEN16 && $urandom_range(0, 5) == 0)
                len = 64'($urandom_range(126, 300));
            push_frame(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), masked, kind,
                       len, $urandom, int'(len));
        end

        // length with the top bit set: the frame stays open to the end of the run
        push_frame(1'b1, OP_BINARY, 1'b1, LEN64, 64'hFFFF_FFFF_FFFF_FF00, $urandom, 12);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (wire_bytes.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
